// File: hdl/mva_pkg.sv
// ----------------------------------------------------------------------------
// mva_pkg
// Shared widths, event codes and structs for the MIDI voice allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package mva_pkg;

  // Default size of the voice table
  localparam int NUM_VOICES_DEF = 16;

  // Field widths
  localparam int KIND_W  = 2;
  localparam int CHAN_W  = 4;
  localparam int NOTE_W  = 7;
  localparam int CTRL_W  = 7;
  localparam int INDEX_W = 4;
  localparam int MASK_W  = 16;

  // Event kinds
  localparam logic [KIND_W-1:0] KIND_NOTE_ON  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_NOTE_OFF = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CONTROL  = 2'd2;

  // Sustain pedal controller and its threshold
  localparam logic [CTRL_W-1:0] CTRL_SUSTAIN   = 7'h40;
  localparam logic [CTRL_W-1:0] PEDAL_DOWN_MIN = 7'd64;

  // One latched event
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CHAN_W-1:0] channel;
    logic              all_channels;
    logic [NOTE_W-1:0] note_number;
    logic              all_notes;
    logic [CTRL_W-1:0] controller;
    logic [CTRL_W-1:0] ctrl_value;
  } mva_cmd_t;

  // Stored part of a voice
  typedef struct packed {
    logic [CHAN_W-1:0] channel;
    logic [NOTE_W-1:0] note;
  } mva_entry_t;

  // Update decided for the voice under evaluation
  typedef struct packed {
    logic take;
    logic set_pressed;
    logic clr_pressed;
    logic set_sus;
    logic clr_sus;
  } mva_action_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } mva_state_t;

endpackage

`default_nettype wire

// File: hdl/mva_if.sv
// ----------------------------------------------------------------------------
// mva_evt_if / mva_res_if
// Valid/ready channels carrying MIDI events in and allocation results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface mva_evt_if;
  import mva_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [CHAN_W-1:0] channel;
  logic              all_channels;
  logic [NOTE_W-1:0] note_number;
  logic              all_notes;
  logic [CTRL_W-1:0] controller;
  logic [CTRL_W-1:0] ctrl_value;

  modport source (
    output valid, kind, channel, all_channels, note_number, all_notes,
           controller, ctrl_value,
    input  ready
  );

  modport sink (
    input  valid, kind, channel, all_channels, note_number, all_notes,
           controller, ctrl_value,
    output ready
  );
endinterface

interface mva_res_if;
  import mva_pkg::*;

  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] voice_index;
  logic               voice_started;
  logic [MASK_W-1:0]  sounding_mask;

  modport source (
    output valid, voice_index, voice_started, sounding_mask,
    input  ready
  );

  modport sink (
    input  valid, voice_index, voice_started, sounding_mask,
    output ready
  );
endinterface

`default_nettype wire

// File: hdl/mva_voice_eval.sv
// ----------------------------------------------------------------------------
// mva_voice_eval
// Shared compare unit: decides the update for one voice against one event.
// ----------------------------------------------------------------------------
`default_nettype none

module mva_voice_eval (
  input  mva_pkg::mva_cmd_t    cmd,
  input  logic                 found,
  input  logic                 pressed,
  input  logic                 sustained,
  input  mva_pkg::mva_entry_t  entry,
  output mva_pkg::mva_action_t act
);
  import mva_pkg::*;

  logic note_hit;
  logic chan_hit;
  logic chan_same;

  // Match terms for note off and sustain
  assign note_hit  = cmd.all_notes || (entry.note == cmd.note_number);
  assign chan_same = (entry.channel == cmd.channel);
  assign chan_hit  = cmd.all_channels || chan_same;

  // Decide the action for this voice
  always_comb begin
    act = '0;
    case (cmd.kind)
      KIND_NOTE_ON: begin
        // take the first voice that is neither pressed nor sustained
        if (!found && !pressed && !sustained) begin
          act.take        = 1'b1;
          act.set_pressed = 1'b1;
        end
      end
      KIND_NOTE_OFF: begin
        act.clr_pressed = pressed && note_hit && chan_hit;
      end
      KIND_CONTROL: begin
        if (cmd.controller == CTRL_SUSTAIN && chan_same) begin
          if (cmd.ctrl_value >= PEDAL_DOWN_MIN) begin
            act.set_sus = pressed;
          end else begin
            act.clr_sus = 1'b1;
          end
        end
      end
      default: begin
        act = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/mva_voice_table.sv
// ----------------------------------------------------------------------------
// mva_voice_table
// Voice state: pressed and sustained flags in flops, channel and note in a
// single-port-read memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mva_voice_table #(
  parameter int NUM_VOICES = mva_pkg::NUM_VOICES_DEF,
  localparam int VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        rd_en,
  input  logic [VW-1:0]               rd_addr,
  output mva_pkg::mva_entry_t         rd_entry,
  input  logic [VW-1:0]               cur_addr,
  input  logic                        act_en,
  input  mva_pkg::mva_action_t        act,
  input  mva_pkg::mva_entry_t         wr_entry,
  output logic                        cur_pressed,
  output logic                        cur_sustained,
  output logic [mva_pkg::MASK_W-1:0]  mask
);
  import mva_pkg::*;

  logic [NUM_VOICES-1:0] pressed;
  logic [NUM_VOICES-1:0] sustained;
  mva_entry_t            mem [NUM_VOICES];

  // Channel and note store: read one entry ahead, write the taken voice
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_entry <= mem[rd_addr];
    end
    if (act_en && act.take) begin
      mem[cur_addr] <= wr_entry;
    end
  end

  // Pressed and sustained flags for the voice under evaluation
  always_ff @(posedge clk) begin
    if (rst) begin
      pressed   <= '0;
      sustained <= '0;
    end else if (act_en) begin
      if (act.set_pressed) begin
        pressed[cur_addr] <= 1'b1;
      end else if (act.clr_pressed) begin
        pressed[cur_addr] <= 1'b0;
      end
      if (act.set_sus) begin
        sustained[cur_addr] <= 1'b1;
      end else if (act.clr_sus) begin
        sustained[cur_addr] <= 1'b0;
      end
    end
  end

  assign cur_pressed   = pressed[cur_addr];
  assign cur_sustained = sustained[cur_addr];

  // Sounding mask covers the low voices only
  for (genvar i = 0; i < MASK_W; i++) begin : g_mask
    if (i < NUM_VOICES) begin : g_live
      assign mask[i] = pressed[i] | sustained[i];
    end else begin : g_none
      assign mask[i] = 1'b0;
    end
  end

  // A taken voice is pressed on the next cycle
  a_take_pressed: assert property (@(posedge clk) disable iff (rst)
    (act_en && act.take) |=> pressed[$past(cur_addr)])
    else $error("taken voice not marked pressed");

  // Sustain set and clear never fire together
  a_sus_excl: assert property (@(posedge clk) disable iff (rst)
    act_en |-> !(act.set_sus && act.clr_sus))
    else $error("sustain set and clear together");

  // Reset leaves no voice sounding
  a_reset_clear: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> (pressed == '0 && sustained == '0))
    else $error("voice flags not cleared by reset");

endmodule

`default_nettype wire

// File: hdl/midi_voice_allocator_unit.sv
// ----------------------------------------------------------------------------
// midi_voice_allocator_unit
// Polyphonic voice allocator driven by MIDI note and sustain events.
// ----------------------------------------------------------------------------
// Each event is latched and then checked against the voice table one voice
// per cycle through a single compare unit, the table memory being read one
// entry ahead of the evaluation. An event occupies the block from acceptance
// to the next acceptance, passing through the accept state, the scan (paced
// by the one memory read port) and the state that loads the result register.
// The result is held in that register until taken; a new event is accepted
// meanwhile, and its result is loaded once the previous one has gone.
`default_nettype none

module midi_voice_allocator_unit #(
  parameter int NUM_VOICES = mva_pkg::NUM_VOICES_DEF
) (
  input  logic clk,
  input  logic rst,
  mva_evt_if.sink   evt,
  mva_res_if.source res
);
  import mva_pkg::*;

  localparam int VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int CW = $clog2(NUM_VOICES + 1);

  mva_state_t         state;
  mva_cmd_t           cmd;
  logic [CW-1:0]      cnt;
  logic               issue;
  logic               eval_valid;
  logic [VW-1:0]      cur_voice;
  logic               found;
  logic [VW-1:0]      voice_idx;
  logic               res_valid;
  logic [INDEX_W-1:0] res_index;
  logic               res_started;
  logic [MASK_W-1:0]  res_mask;

  mva_entry_t         rd_entry;
  mva_entry_t         wr_entry;
  mva_action_t        act;
  logic               cur_pressed;
  logic               cur_sustained;
  logic [MASK_W-1:0]  mask;

  // Read the next voice while voices remain
  assign issue = (state == ST_SCAN) && (cnt != CW'(NUM_VOICES));

  assign wr_entry.channel = cmd.channel;
  assign wr_entry.note    = cmd.note_number;

  mva_voice_table #(
    .NUM_VOICES (NUM_VOICES)
  ) u_table (
    .clk           (clk),
    .rst           (rst),
    .rd_en         (issue),
    .rd_addr       (cnt[VW-1:0]),
    .rd_entry      (rd_entry),
    .cur_addr      (cur_voice),
    .act_en        (eval_valid),
    .act           (act),
    .wr_entry      (wr_entry),
    .cur_pressed   (cur_pressed),
    .cur_sustained (cur_sustained),
    .mask          (mask)
  );

  mva_voice_eval u_eval (
    .cmd       (cmd),
    .found     (found),
    .pressed   (cur_pressed),
    .sustained (cur_sustained),
    .entry     (rd_entry),
    .act       (act)
  );

  // Sequencer: latch, scan, load result
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      eval_valid <= 1'b0;
      found      <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      eval_valid <= issue;
      if (res_valid && res.ready && (state != ST_FINISH)) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (evt.valid) begin
            cmd.kind         <= evt.kind;
            cmd.channel      <= evt.channel;
            cmd.all_channels <= evt.all_channels;
            cmd.note_number  <= evt.note_number;
            cmd.all_notes    <= evt.all_notes;
            cmd.controller   <= evt.controller;
            cmd.ctrl_value   <= evt.ctrl_value;
            cnt              <= '0;
            state            <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (issue) begin
            cnt       <= cnt + CW'(1);
            cur_voice <= cnt[VW-1:0];
          end else begin
            // last voice is evaluated this cycle
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!res_valid || res.ready) begin
            res_valid   <= 1'b1;
            res_index   <= found ? INDEX_W'(voice_idx) : '0;
            res_started <= found;
            res_mask    <= mask;
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      // remember the voice taken by a note on
      if (state == ST_IDLE) begin
        found <= 1'b0;
      end else if (eval_valid && act.take) begin
        found     <= 1'b1;
        voice_idx <= cur_voice;
      end
    end
  end

  assign evt.ready         = (state == ST_IDLE);
  assign res.valid         = res_valid;
  assign res.voice_index   = res_index;
  assign res.voice_started = res_started;
  assign res.sounding_mask = res_mask;

  // Evaluation runs only inside a scan
  a_eval_in_scan: assert property (@(posedge clk) disable iff (rst)
    eval_valid |-> (state == ST_SCAN))
    else $error("voice evaluated outside scan");

  // Scan counter never passes the table size
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (cnt <= CW'(NUM_VOICES)))
    else $error("scan counter out of range");

  // Only a note on can start a voice
  a_start_note_on: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && found) |-> (cmd.kind == KIND_NOTE_ON))
    else $error("voice started by an event other than note on");

endmodule

`default_nettype wire
